/* sv/shp_pkg.sv */
`default_nettype none

package shp_pkg;

    localparam int ADC_W      = 12;
    localparam int ANGLE_W    = 9;
    localparam int DUTY_W     = 15;
    localparam int GAIN_W     = 16;
    localparam int ERR_W      = 10;
    localparam int SUM_W      = 12;
    localparam int DIFF_W     = 11;
    localparam int DRIVE_W    = 30;
    localparam int SCALED_W   = 21;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 40;

    // full scale is 2^ADC_W - 1; the angle divider depends on that
    localparam logic [ADC_W-1:0]   ADC_FULL_SCALE = 12'd4095;
    localparam logic [ANGLE_W-1:0] DEG_FULL       = 9'd360;
    localparam logic [SUM_W:0]     INTEGRAL_LIMIT = 13'd2000;
    localparam logic [DRIVE_W-1:0] DRIVE_LIMIT    = 30'd25600;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET = 2'd0,
        REG_GAIN_P = 2'd1,
        REG_GAIN_I = 2'd2,
        REG_GAIN_D = 2'd3
    } t_reg_idx;

    typedef logic [ANGLE_W-1:0]        t_angle;
    typedef logic [DUTY_W-1:0]         t_duty;
    typedef logic signed [GAIN_W-1:0]  t_gain;
    typedef logic signed [ERR_W-1:0]   t_err;
    typedef logic signed [SUM_W-1:0]   t_sum;
    typedef logic signed [SUM_W:0]     t_sum_raw;
    typedef logic signed [DIFF_W-1:0]  t_diff;
    typedef logic signed [25:0]        t_term_p;
    typedef logic signed [27:0]        t_term_i;
    typedef logic signed [26:0]        t_term_d;
    typedef logic signed [DRIVE_W-1:0] t_drive;

    typedef struct packed {
        t_angle target;
        t_gain  kp;
        t_gain  ki;
        t_gain  kd;
    } t_cfg;

    typedef struct packed {
        t_angle  angle;
        t_term_p p;
        t_term_i i;
        t_term_d d;
    } t_terms;

endpackage

`default_nettype wire

/* sv/shp_angle.sv */
`default_nettype none

module shp_angle (
    input  logic [shp_pkg::ADC_W-1:0] i_sample,
    output shp_pkg::t_angle           o_angle
);

    logic [shp_pkg::SCALED_W-1:0] scaled;
    logic [shp_pkg::ANGLE_W-1:0]  q0;
    logic [shp_pkg::ADC_W:0]      rem;
    logic [shp_pkg::ANGLE_W:0]    quo;

    // x/4095: x = q0*4095 + (low + q0), remainder below 2*4095
    always_comb begin
        scaled = shp_pkg::SCALED_W'(i_sample) * shp_pkg::SCALED_W'(shp_pkg::DEG_FULL);
        q0     = scaled[shp_pkg::SCALED_W-1:shp_pkg::ADC_W];
        rem    = (shp_pkg::ADC_W+1)'(scaled[shp_pkg::ADC_W-1:0])
               + (shp_pkg::ADC_W+1)'(q0);
        if (rem >= (shp_pkg::ADC_W+1)'(shp_pkg::ADC_FULL_SCALE)) begin
            quo = (shp_pkg::ANGLE_W+1)'(q0) + (shp_pkg::ANGLE_W+1)'(1);
        end else begin
            quo = (shp_pkg::ANGLE_W+1)'(q0);
        end
        if (quo > (shp_pkg::ANGLE_W+1)'(shp_pkg::DEG_FULL)) begin
            o_angle = shp_pkg::DEG_FULL;
        end else begin
            o_angle = quo[shp_pkg::ANGLE_W-1:0];
        end
    end

endmodule

`default_nettype wire

/* sv/shp_law.sv */
`default_nettype none

module shp_law (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  shp_pkg::t_angle i_angle,
    input  shp_pkg::t_cfg   i_cfg,
    output shp_pkg::t_terms o_terms
);

    shp_pkg::t_sum     r_sum, n_sum;
    shp_pkg::t_err     r_prev;
    shp_pkg::t_terms   r_terms, n_terms;
    shp_pkg::t_err     err;
    shp_pkg::t_sum_raw sum_raw;
    shp_pkg::t_diff    diff;

    always_comb begin
        err = shp_pkg::t_err'({1'b0, i_cfg.target}) - shp_pkg::t_err'({1'b0, i_angle});

        sum_raw = shp_pkg::t_sum_raw'(r_sum) + shp_pkg::t_sum_raw'(err);
        if (sum_raw > $signed(shp_pkg::INTEGRAL_LIMIT)) begin
            n_sum = shp_pkg::t_sum'(shp_pkg::INTEGRAL_LIMIT);
        end else if (sum_raw < -$signed(shp_pkg::INTEGRAL_LIMIT)) begin
            n_sum = shp_pkg::t_sum'(-$signed(shp_pkg::INTEGRAL_LIMIT));
        end else begin
            n_sum = sum_raw[shp_pkg::SUM_W-1:0];
        end

        diff = shp_pkg::t_diff'(err) - shp_pkg::t_diff'(r_prev);

        n_terms.angle = i_angle;
        n_terms.p     = shp_pkg::t_term_p'(i_cfg.kp) * shp_pkg::t_term_p'(err);
        n_terms.i     = shp_pkg::t_term_i'(i_cfg.ki) * shp_pkg::t_term_i'(n_sum);
        n_terms.d     = shp_pkg::t_term_d'(i_cfg.kd) * shp_pkg::t_term_d'(diff);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_prev <= '0;
        end else if (i_load) begin
            r_sum  <= n_sum;
            r_prev <= err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_terms <= n_terms;
        end
    end

    assign o_terms = r_terms;

endmodule

`default_nettype wire

/* sv/shp_drive.sv */
`default_nettype none

module shp_drive (
    input  shp_pkg::t_terms i_terms,
    output shp_pkg::t_duty  o_duty_ccw,
    output shp_pkg::t_duty  o_duty_cw
);

    shp_pkg::t_drive total;
    shp_pkg::t_drive sat;
    shp_pkg::t_drive mag;

    always_comb begin
        total = shp_pkg::t_drive'(i_terms.p)
              + shp_pkg::t_drive'(i_terms.i)
              + shp_pkg::t_drive'(i_terms.d);
        if (total > $signed(shp_pkg::DRIVE_LIMIT)) begin
            sat = $signed(shp_pkg::DRIVE_LIMIT);
        end else if (total < -$signed(shp_pkg::DRIVE_LIMIT)) begin
            sat = -$signed(shp_pkg::DRIVE_LIMIT);
        end else begin
            sat = total;
        end
        mag = -sat;
        if (sat[shp_pkg::DRIVE_W-1]) begin
            o_duty_ccw = '0;
            o_duty_cw  = mag[shp_pkg::DUTY_W-1:0];
        end else begin
            o_duty_ccw = sat[shp_pkg::DUTY_W-1:0];
            o_duty_cw  = '0;
        end
    end

endmodule

`default_nettype wire

/* sv/servo_pid_hbridge.sv */
// PID position loop for a potentiometer servo driving an H-bridge.
//
// Configuration: write target_angle (index 0) and the Q8.8 gains p, i, d
// (indexes 1..3) on the cfg channel while no sample is in flight.
// o_cfg_ready is always high. Index 0 takes i_cfg_data[8:0].
// Input: one 12-bit sensor sample per request on the s_axis channel.
// Output: one request per sample on m_axis: angle, duty_ccw, duty_cw.
// The angle is registered at accept, then error, integrator and products
// in the product stage, then drive sum, clamp and split into the output
// register.
// One sample is taken per cycle while the pipeline is not stalled; the integrator
// and the previous error update in the product stage together with the products.
// Stall: each stage holds while the one after it is full, so the pipeline
// holds up to three samples while a result waits; the output holds until
// taken.
// Reset clears the pipeline valids, the error sum, the previous error and
// the configuration (target and gains become zero).
`default_nettype none

module servo_pid_hbridge (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [shp_pkg::S_TDATA_W-1:0]    s_axis_tdata,  // [11:0] adc_sample
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [shp_pkg::M_TDATA_W-1:0]    m_axis_tdata,  // [8:0] angle, [23:9] duty_ccw,
                                                            // [38:24] duty_cw
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [shp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [shp_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    shp_pkg::t_cfg   r_cfg;
    logic            r_v1, r_v2, r_v3;
    shp_pkg::t_angle r_angle;
    shp_pkg::t_angle angle_in;
    shp_pkg::t_terms terms;
    shp_pkg::t_duty  duty_ccw, duty_cw;
    logic [shp_pkg::M_TDATA_W-1:0] r_tdata;
    logic            out_free, ready2, ready1, adv1;

    assign out_free      = !r_v3 || m_axis_tready;
    assign ready2        = !r_v2 || out_free;
    assign ready1        = !r_v1 || ready2;
    assign adv1          = r_v1 && ready2;
    assign s_axis_tready = ready1;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (shp_pkg::t_reg_idx'(i_cfg_index))
                shp_pkg::REG_TARGET: r_cfg.target <= i_cfg_data[shp_pkg::ANGLE_W-1:0];
                shp_pkg::REG_GAIN_P: r_cfg.kp     <= i_cfg_data;
                shp_pkg::REG_GAIN_I: r_cfg.ki     <= i_cfg_data;
                shp_pkg::REG_GAIN_D: r_cfg.kd     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (ready1) begin
                r_v1 <= s_axis_tvalid;
            end
            if (ready2) begin
                r_v2 <= r_v1;
            end
            if (out_free) begin
                r_v3 <= r_v2;
            end
        end
    end

    shp_angle u_angle (
        .i_sample (s_axis_tdata[shp_pkg::ADC_W-1:0]),
        .o_angle  (angle_in)
    );

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && ready1) begin
            r_angle <= angle_in;
        end
    end

    shp_law u_law (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (adv1),
        .i_angle (r_angle),
        .i_cfg   (r_cfg),
        .o_terms (terms)
    );

    shp_drive u_drive (
        .i_terms    (terms),
        .o_duty_ccw (duty_ccw),
        .o_duty_cw  (duty_cw)
    );

    always_ff @(posedge i_clk) begin
        if (r_v2 && out_free) begin
            r_tdata <= {1'b0, duty_cw, duty_ccw, terms.angle};
        end
    end

    assign m_axis_tvalid = r_v3;
    assign m_axis_tdata  = r_tdata;

endmodule

`default_nettype wire

/* sv/shp_chk.sv */
`default_nettype none

module shp_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [shp_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_one_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[23:9] == 15'd0 || m_axis_tdata[38:24] == 15'd0))
        else $error("both bridge channels driven");

    a_ranges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[8:0] <= 9'd360 && m_axis_tdata[23:9] <= 15'd25600
                           && m_axis_tdata[38:24] <= 15'd25600 && !m_axis_tdata[39]))
        else $error("result out of range");

endmodule

bind servo_pid_hbridge shp_chk u_shp_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

/* bench/tb_servo_pid_hbridge.sv */
module tb_servo_pid_hbridge;

    localparam int FULL_TURN     = 360;
    localparam int ADC_SPAN      = 4095;
    localparam int SUM_CLAMP     = 2000;
    localparam int DRIVE_CLAMP   = 25600;
    localparam int SETTLE_CYCLES = 6;
    localparam int LIMIT_CYCLES  = 200_000;
    localparam int N_DIR         = 21;
    localparam int BLOCK_ITEMS   = 46;

    typedef struct packed {
        shp_pkg::t_angle angle;
        shp_pkg::t_duty  duty_ccw;
        shp_pkg::t_duty  duty_cw;
    } t_drive_result;

    typedef struct packed {
        bit            load;
        logic [15:0]   tgt;
        logic [15:0]   kp;
        logic [15:0]   ki;
        logic [15:0]   kd;
        logic [11:0]   smp;
        bit            typed;
        t_drive_result want;
    } t_dir_row;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n;
    logic                               s_axis_tvalid;
    logic                               s_axis_tready;
    logic [shp_pkg::S_TDATA_W-1:0]      s_axis_tdata;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready = 1'b0;
    logic [shp_pkg::M_TDATA_W-1:0]      m_axis_tdata;
    logic                               i_cfg_valid;
    logic                               o_cfg_ready;
    logic [shp_pkg::CFG_IDX_W-1:0]      i_cfg_index;
    logic [shp_pkg::CFG_DATA_W-1:0]     i_cfg_data;

    // loop state mirrored from the block
    shp_pkg::t_angle set_angle;
    int     kp_q8, ki_q8, kd_q8;
    int     err_acc, last_err;

    t_drive_result drive_due_q[$];
    int src_idle_pct, sink_stall_pct;
    int fail_count, result_count;

    int SRC_PCT  [4] = '{0, 46, 0, 35};
    int SINK_PCT [4] = '{0, 0, 46, 35};

    // load, target, kp, ki, kd, sample, typed, {angle, ccw, cw}
    t_dir_row dir_table [N_DIR] = '{
        '{1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 12'd0,    1'b1, '{9'd0,   15'd0,     15'd0}},
        '{1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 12'd4095, 1'b1, '{9'd360, 15'd0,     15'd0}},
        '{1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 12'd2048, 1'b1, '{9'd180, 15'd0,     15'd0}},
        '{1'b1, 16'hFFFF, 16'h7FFF, 16'h0000, 16'h0000, 12'd0,    1'b1, '{9'd0,   15'd25600, 15'd0}},
        '{1'b1, 16'h0000, 16'h7FFF, 16'h0000, 16'h0000, 12'd4095, 1'b1, '{9'd360, 15'd0,     15'd25600}},
        '{1'b1, 16'h0000, 16'h8000, 16'h0000, 16'h0000, 12'd4095, 1'b1, '{9'd360, 15'd25600, 15'd0}},
        '{1'b1, 16'h0000, 16'h0001, 16'h0000, 16'h0000, 12'd4095, 1'b1, '{9'd360, 15'd0,     15'd360}},
        '{1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 12'd0,    1'b1, '{9'd0,   15'd0,     15'd0}},
        // integrator walks up into its clamp
        '{1'b1, 16'hFFFF, 16'h0000, 16'h0100, 16'h0000, 12'd0,    1'b0, '0},
        '{1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 12'd0,    1'b0, '0},
        '{1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 12'd0,    1'b0, '0},
        '{1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 12'd0,    1'b0, '0},
        '{1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 12'd0,    1'b0, '0},
        '{1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 12'd0,    1'b0, '0},
        // derivative swing
        '{1'b1, 16'h00B4, 16'h0000, 16'h0000, 16'h8000, 12'd4095, 1'b0, '0},
        '{1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 12'd0,    1'b0, '0},
        '{1'b1, 16'h00C8, 16'h0180, 16'h0010, 16'hFF00, 12'd2000, 1'b0, '0},
        '{1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 12'd2300, 1'b0, '0},
        '{1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 12'd1,    1'b0, '0},
        '{1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 12'd12,   1'b0, '0},
        '{1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 12'd4094, 1'b0, '0}
    };

    servo_pid_hbridge dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic flag_error(input string msg);
        $display("t=%0t result %0d: %s", $realtime, result_count, msg);
        fail_count++;
    endtask

    function automatic t_drive_result pid_step(input logic [11:0] smp);
        int            ang;
        int            err;
        longint        drv;
        t_drive_result res;
        ang = int'(smp) * FULL_TURN / ADC_SPAN;
        if (ang > FULL_TURN) ang = FULL_TURN;
        err = int'(set_angle) - ang;
        err_acc = err_acc + err;
        if (err_acc > SUM_CLAMP) err_acc = SUM_CLAMP;
        if (err_acc < -SUM_CLAMP) err_acc = -SUM_CLAMP;
        drv = longint'(kp_q8) * err + longint'(ki_q8) * err_acc
            + longint'(kd_q8) * (err - last_err);
        last_err = err;
        if (drv > DRIVE_CLAMP) drv = DRIVE_CLAMP;
        if (drv < -DRIVE_CLAMP) drv = -DRIVE_CLAMP;
        res.angle    = shp_pkg::t_angle'(ang);
        res.duty_ccw = (drv >= 0) ? shp_pkg::t_duty'(drv) : '0;
        res.duty_cw  = (drv < 0) ? shp_pkg::t_duty'(-drv) : '0;
        return res;
    endfunction

    task automatic write_reg(input shp_pkg::t_reg_idx idx, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            shp_pkg::REG_TARGET: set_angle = data[shp_pkg::ANGLE_W-1:0];
            shp_pkg::REG_GAIN_P: kp_q8 = int'($signed(data));
            shp_pkg::REG_GAIN_I: ki_q8 = int'($signed(data));
            shp_pkg::REG_GAIN_D: kd_q8 = int'($signed(data));
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic write_regs(input logic [15:0] tgt, kp, ki, kd);
        write_reg(shp_pkg::REG_TARGET, tgt);
        write_reg(shp_pkg::REG_GAIN_P, kp);
        write_reg(shp_pkg::REG_GAIN_I, ki);
        write_reg(shp_pkg::REG_GAIN_D, kd);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (drive_due_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // entered and left at a falling edge
    task automatic push_sample(input logic [11:0] smp, input bit typed,
                               input t_drive_result typed_res);
        int            gap;
        t_drive_result res;
        gap = 0;
        while (gap < 16 && $urandom_range(99) < src_idle_pct) gap++;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= shp_pkg::S_TDATA_W'(smp);
        do @(posedge i_clk); while (!s_axis_tready);
        res = pid_step(smp);
        drive_due_q.push_back(typed ? typed_res : res);
        @(negedge i_clk);
    endtask

    function automatic logic [15:0] pick_gain();
        int sel;
        sel = $urandom_range(9);
        if (sel <= 4) return 16'(int'($urandom_range(600)) - 300);
        if (sel <= 6) return 16'($urandom);
        if (sel == 7) return 16'h7FFF;
        if (sel == 8) return 16'h8000;
        return 16'h0000;
    endfunction

    always @(negedge i_clk) begin
        m_axis_tready <= (sink_stall_pct == 0) || ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin
        t_drive_result got;
        t_drive_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.angle    = m_axis_tdata[shp_pkg::ANGLE_W-1:0];
            got.duty_ccw = m_axis_tdata[shp_pkg::ANGLE_W +: shp_pkg::DUTY_W];
            got.duty_cw  = m_axis_tdata[shp_pkg::ANGLE_W+shp_pkg::DUTY_W +: shp_pkg::DUTY_W];
            if (drive_due_q.size() == 0) begin
                flag_error("output request with nothing pending");
            end else begin
                want = drive_due_q.pop_front();
                if (got.angle !== want.angle)
                    flag_error($sformatf("angle got %0d want %0d", got.angle, want.angle));
                if (got.duty_ccw !== want.duty_ccw)
                    flag_error($sformatf("duty_ccw got %0d want %0d",
                                         got.duty_ccw, want.duty_ccw));
                if (got.duty_cw !== want.duty_cw)
                    flag_error($sformatf("duty_cw got %0d want %0d",
                                         got.duty_cw, want.duty_cw));
            end
            result_count++;
        end
    end

    initial begin
        #(LIMIT_CYCLES * 20);
        $display("[servo_pid_hbridge] ERROR");
        $finish;
    end

    initial begin
        shp_pkg::t_angle tgt;
        int     sel;
        int     center;
        int     smp_v;
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = shp_pkg::REG_TARGET;
        i_cfg_data     = '0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        fail_count     = 0;
        result_count   = 0;
        set_angle      = '0;
        kp_q8          = 0;
        ki_q8          = 0;
        kd_q8          = 0;
        err_acc        = 0;
        last_err       = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < N_DIR; r++) begin
            if (dir_table[r].load) begin
                s_axis_tvalid <= 1'b0;
                wait_idle();
                write_regs(dir_table[r].tgt, dir_table[r].kp, dir_table[r].ki,
                           dir_table[r].kd);
            end
            push_sample(dir_table[r].smp, dir_table[r].typed, dir_table[r].want);
        end

        for (int ph = 0; ph < 4; ph++) begin
            src_idle_pct   = SRC_PCT[ph];
            sink_stall_pct = SINK_PCT[ph];
            for (int blk = 0; blk < 3; blk++) begin
                s_axis_tvalid <= 1'b0;
                wait_idle();
                sel = $urandom_range(9);
                if (sel <= 6)      tgt = 9'($urandom_range(360));
                else if (sel == 7) tgt = 9'd0;
                else if (sel == 8) tgt = 9'd360;
                else               tgt = 9'($urandom_range(511, 361));
                write_regs({7'($urandom), tgt}, pick_gain(), pick_gain(), pick_gain());
                for (int n = 0; n < BLOCK_ITEMS; n++) begin
                    // mostly samples around the set point
                    sel = $urandom_range(9);
                    if (sel <= 5) begin
                        center = int'(tgt) * ADC_SPAN / FULL_TURN;
                        smp_v  = center + int'($urandom_range(160)) - 80;
                        if (smp_v < 0) smp_v = 0;
                        if (smp_v > ADC_SPAN) smp_v = ADC_SPAN;
                    end else if (sel <= 8) begin
                        smp_v = $urandom_range(ADC_SPAN);
                    end else begin
                        smp_v = $urandom_range(1) ? ADC_SPAN : 0;
                    end
                    push_sample(12'(smp_v), 1'b0, '0);
                end
            end
        end

        s_axis_tvalid <= 1'b0;
        wait_idle();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("[servo_pid_hbridge] OK");
        end else begin
            $display("[servo_pid_hbridge] ERROR");
        end
        $finish;
    end

endmodule
